FILE: rtl/core/apce_pkg.sv
// Shared types and constants of the ATAPI packet command engine.
`default_nettype none

package apce_pkg;

   // request kinds
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_POLL  = 2'd2;
   localparam logic [1:0] REQ_LOAD  = 2'd3;

   // result actions
   localparam logic [2:0] ACT_WAIT     = 3'd0;
   localparam logic [2:0] ACT_HEAD     = 3'd1;
   localparam logic [2:0] ACT_PACKET   = 3'd2;
   localparam logic [2:0] ACT_WRITE    = 3'd3;
   localparam logic [2:0] ACT_STORE    = 3'd4;
   localparam logic [2:0] ACT_FINISH   = 3'd5;
   localparam logic [2:0] ACT_PKT_READ = 3'd6;

   // completion codes
   localparam logic [2:0] STS_OK          = 3'd0;
   localparam logic [2:0] STS_BAD_DEVICE  = 3'd1;
   localparam logic [2:0] STS_SEL_TIMEOUT = 3'd2;
   localparam logic [2:0] STS_CMD_TIMEOUT = 3'd3;
   localparam logic [2:0] STS_DEV_ERROR   = 3'd4;

   // interrupt reason codes
   localparam logic [1:0] RSN_DATA_OUT   = 2'd0;
   localparam logic [1:0] RSN_PACKET_OUT = 2'd1;
   localparam logic [1:0] RSN_DATA_IN    = 2'd2;
   localparam logic [1:0] RSN_PACKET_IN  = 2'd3;

   // sequencer phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SEL1 = 2'd1;
   localparam logic [1:0] PH_SEL2 = 2'd2;
   localparam logic [1:0] PH_XFER = 2'd3;

   // status register masks
   localparam logic [7:0] STAT_BSY_DRDY = 8'hC0;
   localparam logic [7:0] STAT_DRDY     = 8'h40;
   localparam logic [7:0] STAT_ACTIVE   = 8'h89;
   localparam logic [7:0] STAT_BSY      = 8'h80;
   localparam logic [7:0] STAT_CHK      = 8'h01;

   localparam logic [7:0] HEAD_MASTER   = 8'hA0;
   localparam logic [7:0] HEAD_SLAVE    = 8'hB0;
   localparam logic [7:0] DEVICE_MAX    = 8'h03;
   localparam logic [7:0] TIMEOUT_RESET = 8'd200;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  device;
      logic [31:0] transfer_length;
      logic [2:0]  packet_index;
      logic [15:0] host_word;
      logic [7:0]  status;
      logic [1:0]  reason;
      logic [7:0]  error_value;
      logic [15:0] device_word;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        channel;
      logic [7:0]  head_value;
      logic [15:0] data_word;
      logic [31:0] buf_offset;
      logic [1:0]  byte_count;
      logic [2:0]  status_code;
      logic [7:0]  error_byte;
      logic        done_res;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [1:0]  selected_device;
      logic [31:0] remaining_bytes;
      logic [31:0] data_offset;
      logic [7:0]  elapsed_ticks;
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/atapi_packet_command_engine.sv
// ATAPI PIO packet command engine: handshake registers, state and packet store.
//
// Request channel (req_*): one transfer per item; req_type selects start, tick,
// status poll or packet word load, and the other fields carry its operands.
// Result channel (rsp_*): exactly one result transfer per request transfer, in
// order. Configuration (csr_*): csr_wr_en writes csr_wr_data into the timeout
// register (ticks allowed per wait phase); write only while the engine is idle.
// Path: a request taken sits in the input register, is decoded there against
// the sequencer state, and its result is captured in the result register,
// which presents it on rsp_valid; a stalled result holds back the decode.
// Throughput: one item per cycle unless rsp_stall holds a pending result; the
// state update is a single pass of compare and 32-bit add/subtract logic
// between the input and result registers.
// Stall: while rsp_stall holds a pending result, one more request is taken into
// the input register, then req_stall rises until the result transfers.
// Reset: synchronous; sequencer idle, drive 0, counts cleared, timeout 200,
// both registers empty. Packet store contents are undefined until loaded.
`default_nettype none

module atapi_packet_command_engine #(
   parameter int PACKET_WORDS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_device,
   input  wire logic [31:0] req_transfer_length,
   input  wire logic [2:0]  req_packet_index,
   input  wire logic [15:0] req_host_word,
   input  wire logic [7:0]  req_status,
   input  wire logic [1:0]  req_reason,
   input  wire logic [7:0]  req_error_value,
   input  wire logic [15:0] req_device_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_action,
   output logic             rsp_channel,
   output logic [7:0]       rsp_head_value,
   output logic [15:0]      rsp_data_word,
   output logic [31:0]      rsp_buf_offset,
   output logic [1:0]       rsp_byte_count,
   output logic [2:0]       rsp_status_code,
   output logic [7:0]       rsp_error_byte,
   output logic             rsp_done_res,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   localparam int PTR_W = $clog2(PACKET_WORDS);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   apce_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   apce_pkg::rsp_item_type out_item_ff;
   apce_pkg::state_type    state_ff;
   apce_pkg::state_type    state_in;
   logic [PTR_W-1:0]       ptr_ff;
   logic [PTR_W-1:0]       ptr_in;
   logic [7:0]             timeout_ff;
   logic [15:0]            pkt_store_ff [PACKET_WORDS];

   apce_pkg::rsp_item_type step_rsp;
   logic                   st_we;
   logic [PTR_W-1:0]       st_addr;
   logic [15:0]            st_data;
   logic                   req_take;
   logic                   step_fire;

   assign step_fire    = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall    = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !step_fire);
   assign out_valid_in = step_fire || (out_valid_ff && rsp_stall);

   apce_step #(
      .PACKET_WORDS(PACKET_WORDS)
   ) u_step (
      .item      (in_item_ff),
      .state_cur (state_ff),
      .ptr_cur   (ptr_ff),
      .pkt_word  (pkt_store_ff[ptr_ff]),
      .timeout   (timeout_ff),
      .rsp       (step_rsp),
      .state_nxt (state_in),
      .ptr_nxt   (ptr_in),
      .st_we     (st_we),
      .st_addr   (st_addr),
      .st_data   (st_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         ptr_ff       <= '0;
         timeout_ff   <= apce_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
            ptr_ff   <= ptr_in;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.req_type        <= req_type;
         in_item_ff.device          <= req_device;
         in_item_ff.transfer_length <= req_transfer_length;
         in_item_ff.packet_index    <= req_packet_index;
         in_item_ff.host_word       <= req_host_word;
         in_item_ff.status          <= req_status;
         in_item_ff.reason          <= req_reason;
         in_item_ff.error_value     <= req_error_value;
         in_item_ff.device_word     <= req_device_word;
      end
      if (step_fire) begin
         out_item_ff <= step_rsp;
      end
      if (step_fire && st_we) begin
         pkt_store_ff[st_addr] <= st_data;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = out_item_ff.action;
   assign rsp_channel     = out_item_ff.channel;
   assign rsp_head_value  = out_item_ff.head_value;
   assign rsp_data_word   = out_item_ff.data_word;
   assign rsp_buf_offset  = out_item_ff.buf_offset;
   assign rsp_byte_count  = out_item_ff.byte_count;
   assign rsp_status_code = out_item_ff.status_code;
   assign rsp_error_byte  = out_item_ff.error_byte;
   assign rsp_done_res    = out_item_ff.done_res;

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (state_ff.phase == apce_pkg::PH_IDLE && !out_valid_ff && !in_valid_ff))
      else $error("engine not idle after reset");

   a_idle_no_ticks: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == apce_pkg::PH_IDLE) |-> (state_ff.elapsed_ticks == 8'd0))
      else $error("tick count left over in idle phase");

   a_remaining_falls: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_item_ff.req_type != apce_pkg::REQ_START)
      |=> (state_ff.remaining_bytes <= $past(state_ff.remaining_bytes)))
      else $error("remaining byte count grew outside a start");

   a_bytes_on_move: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.byte_count != 2'd0)
      |-> (out_item_ff.action == apce_pkg::ACT_WRITE
           || out_item_ff.action == apce_pkg::ACT_STORE
           || out_item_ff.action == apce_pkg::ACT_PKT_READ))
      else $error("byte count on a result that moves no word");

   a_done_finish: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_item_ff.done_res == (out_item_ff.action == apce_pkg::ACT_FINISH)))
      else $error("done flag disagrees with finish action");

endmodule

`default_nettype wire

FILE: rtl/core/apce_step.sv
// Per-item sequencer logic: next state, packet store write and result for one item.
`default_nettype none

module apce_step #(
   parameter int PACKET_WORDS = 8
) (
   input  wire apce_pkg::req_item_type              item,
   input  wire apce_pkg::state_type                 state_cur,
   input  wire logic [$clog2(PACKET_WORDS)-1:0]     ptr_cur,
   input  wire logic [15:0]                         pkt_word,
   input  wire logic [7:0]                          timeout,
   output apce_pkg::rsp_item_type                   rsp,
   output apce_pkg::state_type                      state_nxt,
   output logic [$clog2(PACKET_WORDS)-1:0]          ptr_nxt,
   output logic                                     st_we,
   output logic [$clog2(PACKET_WORDS)-1:0]          st_addr,
   output logic [15:0]                              st_data
);

   localparam int PTR_W = $clog2(PACKET_WORDS);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PACKET_WORDS - 1);

   logic             ready;
   logic             rem_many;
   logic             rem_one;
   logic [15:0]      in_word;
   logic [PTR_W-1:0] ptr_inc;

   assign ready    = (item.status & apce_pkg::STAT_BSY_DRDY) == apce_pkg::STAT_DRDY;
   assign rem_many = state_cur.remaining_bytes > 32'd1;
   assign rem_one  = state_cur.remaining_bytes == 32'd1;
   assign ptr_inc  = (ptr_cur == PTR_LAST) ? '0 : ptr_cur + PTR_W'(1);
   assign in_word  = (item.reason == apce_pkg::RSN_DATA_OUT) ? item.host_word
                                                              : item.device_word;

   always_comb begin
      rsp       = '0;
      state_nxt = state_cur;
      ptr_nxt   = ptr_cur;
      st_we     = 1'b0;
      st_addr   = ptr_cur;
      st_data   = item.device_word;
      rsp.action = apce_pkg::ACT_WAIT;

      case (item.req_type)
         apce_pkg::REQ_START: begin
            if (item.device > apce_pkg::DEVICE_MAX) begin
               rsp.action                = apce_pkg::ACT_FINISH;
               rsp.status_code           = apce_pkg::STS_BAD_DEVICE;
               rsp.done_res              = 1'b1;
               state_nxt.phase           = apce_pkg::PH_IDLE;
               state_nxt.elapsed_ticks   = '0;
            end else begin
               state_nxt.selected_device = item.device[1:0];
               state_nxt.remaining_bytes = item.transfer_length;
               state_nxt.data_offset     = '0;
               state_nxt.elapsed_ticks   = '0;
               state_nxt.phase           = apce_pkg::PH_SEL1;
               ptr_nxt                   = '0;
            end
         end
         apce_pkg::REQ_TICK: begin
            if (state_cur.phase != apce_pkg::PH_IDLE) begin
               if (state_cur.elapsed_ticks >= timeout) begin
                  rsp.action      = apce_pkg::ACT_FINISH;
                  rsp.status_code = (state_cur.phase == apce_pkg::PH_XFER)
                                    ? apce_pkg::STS_CMD_TIMEOUT
                                    : apce_pkg::STS_SEL_TIMEOUT;
                  rsp.done_res            = 1'b1;
                  state_nxt.phase         = apce_pkg::PH_IDLE;
                  state_nxt.elapsed_ticks = '0;
               end else begin
                  state_nxt.elapsed_ticks = state_cur.elapsed_ticks + 8'd1;
               end
            end
         end
         apce_pkg::REQ_POLL: begin
            case (state_cur.phase)
               apce_pkg::PH_SEL1: begin
                  if (ready) begin
                     rsp.action              = apce_pkg::ACT_HEAD;
                     rsp.head_value          = state_cur.selected_device[0]
                                               ? apce_pkg::HEAD_SLAVE
                                               : apce_pkg::HEAD_MASTER;
                     state_nxt.phase         = apce_pkg::PH_SEL2;
                     state_nxt.elapsed_ticks = '0;
                  end
               end
               apce_pkg::PH_SEL2: begin
                  if (ready) begin
                     rsp.action              = apce_pkg::ACT_PACKET;
                     state_nxt.phase         = apce_pkg::PH_XFER;
                     state_nxt.elapsed_ticks = '0;
                  end
               end
               apce_pkg::PH_XFER: begin
                  if ((item.status & apce_pkg::STAT_ACTIVE) == 8'h00) begin
                     rsp.action              = apce_pkg::ACT_FINISH;
                     rsp.status_code         = apce_pkg::STS_OK;
                     rsp.done_res            = 1'b1;
                     state_nxt.phase         = apce_pkg::PH_IDLE;
                     state_nxt.elapsed_ticks = '0;
                  end else if ((item.status & apce_pkg::STAT_BSY) != 8'h00) begin
                     rsp.action = apce_pkg::ACT_WAIT;
                  end else if ((item.status & apce_pkg::STAT_CHK) != 8'h00) begin
                     rsp.action              = apce_pkg::ACT_FINISH;
                     rsp.status_code         = apce_pkg::STS_DEV_ERROR;
                     rsp.error_byte          = item.error_value;
                     rsp.done_res            = 1'b1;
                     state_nxt.phase         = apce_pkg::PH_IDLE;
                     state_nxt.elapsed_ticks = '0;
                  end else begin
                     state_nxt.elapsed_ticks = '0;
                     case (item.reason)
                        apce_pkg::RSN_DATA_OUT, apce_pkg::RSN_DATA_IN: begin
                           rsp.action     = (item.reason == apce_pkg::RSN_DATA_OUT)
                                            ? apce_pkg::ACT_WRITE
                                            : apce_pkg::ACT_STORE;
                           rsp.buf_offset = state_cur.data_offset;
                           if (rem_many) begin
                              rsp.data_word             = in_word;
                              rsp.byte_count            = 2'd2;
                              state_nxt.remaining_bytes = state_cur.remaining_bytes - 32'd2;
                              state_nxt.data_offset     = state_cur.data_offset + 32'd2;
                           end else if (rem_one) begin
                              rsp.data_word             = {8'h00, in_word[7:0]};
                              rsp.byte_count            = 2'd1;
                              state_nxt.remaining_bytes = '0;
                              state_nxt.data_offset     = state_cur.data_offset + 32'd1;
                           end
                        end
                        apce_pkg::RSN_PACKET_OUT: begin
                           rsp.action     = apce_pkg::ACT_WRITE;
                           rsp.data_word  = pkt_word;
                           rsp.byte_count = 2'd2;
                           ptr_nxt        = ptr_inc;
                        end
                        default: begin
                           rsp.action     = apce_pkg::ACT_PKT_READ;
                           rsp.data_word  = item.device_word;
                           rsp.byte_count = 2'd2;
                           st_we          = 1'b1;
                           ptr_nxt        = ptr_inc;
                        end
                     endcase
                  end
               end
               default: begin
                  rsp.action = apce_pkg::ACT_WAIT;
               end
            endcase
         end
         default: begin
            // slots at or past the packet size are dropped
            if (32'(item.packet_index) < 32'(PACKET_WORDS)) begin
               st_we   = 1'b1;
               st_addr = PTR_W'(item.packet_index);
               st_data = item.host_word;
            end
         end
      endcase

      rsp.channel = state_nxt.selected_device[1];
   end

endmodule

`default_nettype wire
